@@ rtl/bdq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants for the bounded deque: command and status codes, field
// widths and parameter defaults.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

@@ rtl/bdq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/bounded_deque_with_search.sv @@
`default_nettype none
// Push, pop and no-op requests pass through S_RDF, S_RDB and S_OUT, where the response
// is registered; the next request is taken in the cycle after the response is loaded.
// Contains and remove scan the stored values one per cycle through the RAM read port
// until a match or the end of the deque is found, then a remove shifts each later
// value one place toward the front, one per cycle, before the response is built.
// Synchronous active-high reset empties the deque (head 0, count 0); RAM is not cleared.
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue in a ring RAM with push/pop at both ends,
// membership test and removal of the first matching value.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
   parameter int DEPTH       = bdq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [bdq_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic signed [bdq_pkg::DATA_W-1:0]   req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [bdq_pkg::DATA_W-1:0]   rsp_front_value,
   output logic signed      [bdq_pkg::DATA_W-1:0]   rsp_back_value,
   output logic             [bdq_pkg::COUNT_W-1:0]  rsp_count,
   output logic                                     rsp_empty_res,
   output logic                                     rsp_found,
   output logic             [bdq_pkg::STATUS_W-1:0] rsp_status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_RDF   = 3'd3;
   localparam logic [2:0] S_RDB   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [IDX_W-1:0]               head_ff, head_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [CNT_W-1:0]               rd_pos_ff, rd_pos_in;
   logic                           pend_ff, pend_in;
   logic [CNT_W-1:0]               sh_pos_ff, sh_pos_in;
   logic [bdq_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0]         key_ff, key_in;
   logic                           found_ff, found_in;
   logic [bdq_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [VALUE_WIDTH-1:0]         front_tmp_ff, front_tmp_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bdq_pkg::DATA_W-1:0]     rsp_front_ff, rsp_front_in;
   logic [bdq_pkg::DATA_W-1:0]     rsp_back_ff, rsp_back_in;
   logic [bdq_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                           rsp_empty_ff, rsp_empty_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [bdq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                           mem_we;
   logic [IDX_W-1:0]               mem_waddr;
   logic [VALUE_WIDTH-1:0]         mem_wdata;
   logic [IDX_W-1:0]               mem_raddr;
   logic [VALUE_WIDTH-1:0]         mem_rdata;

   logic [VALUE_WIDTH-1:0]         req_key;
   logic [bdq_pkg::DATA_W-1:0]     front_word;
   logic [bdq_pkg::DATA_W-1:0]     back_word;
   logic [bdq_pkg::COUNT_W-1:0]    count_word;
   logic                           full;
   logic                           load_rsp;
   logic [IDX_W-1:0]               head_dec;
   logic [IDX_W-1:0]               head_inc;
   logic [IDX_W-1:0]               back_slot;
   logic [CNT_W-1:0]               back_pos;

   // Ring position of element pos; pos never exceeds DEPTH.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(pos);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   bdq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Width adaptation between the 32-bit ports and the stored value width
   if (VALUE_WIDTH <= bdq_pkg::DATA_W) begin : g_narrow
      assign req_key    = req_value[VALUE_WIDTH-1:0];
      assign front_word = bdq_pkg::DATA_W'(front_tmp_ff);
      assign back_word  = bdq_pkg::DATA_W'(mem_rdata);
   end else begin : g_wide
      assign req_key    = {{(VALUE_WIDTH-bdq_pkg::DATA_W){1'b0}}, req_value};
      assign front_word = front_tmp_ff[bdq_pkg::DATA_W-1:0];
      assign back_word  = mem_rdata[bdq_pkg::DATA_W-1:0];
   end

   if (CNT_W >= bdq_pkg::COUNT_W) begin : g_cnt_trunc
      assign count_word = count_ff[bdq_pkg::COUNT_W-1:0];
   end else begin : g_cnt_ext
      assign count_word = {{(bdq_pkg::COUNT_W-CNT_W){1'b0}}, count_ff};
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_dec  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign back_pos  = (count_ff == '0) ? '0 : count_ff - 1'b1;
   assign back_slot = slot_of(head_ff, back_pos);
   assign load_rsp  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_pos_in    = rd_pos_ff;
      pend_in      = pend_ff;
      sh_pos_in    = sh_pos_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      front_tmp_in = front_tmp_ff;
      mem_we       = 1'b0;
      mem_waddr    = head_ff;
      mem_wdata    = key_ff;
      mem_raddr    = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               found_in  = 1'b0;
               status_in = bdq_pkg::STATUS_OK;
               rd_pos_in = '0;
               pend_in   = 1'b0;
               state_in  = S_RDF;
               unique case (req_cmd) inside
                  bdq_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        status_in = bdq_pkg::STATUS_FULL;
                     end else begin
                        head_in   = head_dec;
                        mem_we    = 1'b1;
                        mem_waddr = head_dec;
                        mem_wdata = req_key;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  bdq_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = bdq_pkg::STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(head_ff, count_ff);
                        mem_wdata = req_key;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  bdq_pkg::CMD_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  bdq_pkg::CMD_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  bdq_pkg::CMD_CONTAINS, bdq_pkg::CMD_REMOVE: begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_RDF;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue the next read while comparing the previous one
            mem_raddr = slot_of(head_ff, rd_pos_ff);
            if (pend_ff && (mem_rdata == key_ff)) begin
               found_in = 1'b1;
               if (cmd_ff == bdq_pkg::CMD_REMOVE) begin
                  sh_pos_in = rd_pos_ff - 1'b1;
                  state_in  = S_SHIFT;
               end else begin
                  state_in = S_RDF;
               end
            end else if (pend_ff && (rd_pos_ff == count_ff)) begin
               state_in = S_RDF;
            end else begin
               rd_pos_in = rd_pos_ff + 1'b1;
               pend_in   = 1'b1;
            end
         end
         S_SHIFT: begin
            // Read data holds the element one place behind sh_pos
            if ((sh_pos_ff + 1'b1) < count_ff) begin
               mem_we    = 1'b1;
               mem_waddr = slot_of(head_ff, sh_pos_ff);
               mem_wdata = mem_rdata;
               mem_raddr = slot_of(head_ff, sh_pos_ff + CNT_W'(2));
               sh_pos_in = sh_pos_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_RDF;
            end
         end
         S_RDF: begin
            mem_raddr = head_ff;
            state_in  = S_RDB;
         end
         S_RDB: begin
            front_tmp_in = mem_rdata;
            mem_raddr    = back_slot;
            state_in     = S_OUT;
         end
         S_OUT: begin
            // Hold the back address so the read data stays put while stalled
            mem_raddr = back_slot;
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_front_in  = (count_ff == '0) ? '0 : front_word;
         rsp_back_in   = (count_ff == '0) ? '0 : back_word;
         rsp_count_in  = count_word;
         rsp_empty_in  = (count_ff == '0);
         rsp_found_in  = found_ff;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_pos_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_pos_ff    <= rd_pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_pos_ff     <= sh_pos_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      front_tmp_ff  <= front_tmp_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stored count exceeds depth");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE || state_ff == S_SHIFT))
      else $error("RAM write outside push or shift");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && mem_we) |-> (mem_waddr != mem_raddr))
      else $error("shift reads and writes the same entry");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start work");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == bdq_pkg::STATUS_OK && !rsp_empty_res
                                    || rsp_status == bdq_pkg::STATUS_OK))
      else $error("found flagged with a refusal status");

endmodule
`default_nettype wire

@@ verif/tb_bounded_deque_with_search.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search
// Drives push, pop, contains, remove and no-op requests into the deque. The sender
// works in bursts and the receiver stalls on its own pattern. A scoreboard
// keeps its own ring model of the deque and checks every response field.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search;

   localparam int DEPTH        = bdq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1620;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 2 * DEPTH + 8;

   // command codes the block treats as no-ops
   localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;

   localparam logic [bdq_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [bdq_pkg::DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

   typedef enum int {TREND_GROW, TREND_SHRINK, TREND_CHURN} fill_trend_type;

   typedef struct packed {
      logic signed [bdq_pkg::DATA_W-1:0]   front_value;
      logic signed [bdq_pkg::DATA_W-1:0]   back_value;
      logic        [bdq_pkg::COUNT_W-1:0]  count;
      logic                                empty_res;
      logic                                found;
      logic        [bdq_pkg::STATUS_W-1:0] status;
   } deque_view_type;

   class deque_scoreboard;
      logic [bdq_pkg::DATA_W-1:0] slots [DEPTH];
      int                         head_pos;
      int                         fill;
      int                         errors;
      deque_view_type             expected_q [$];

      function new();
         head_pos = 0;
         fill     = 0;
         errors   = 0;
      endfunction

      function logic [bdq_pkg::DATA_W-1:0] slot_at(int pos);
         return slots[(head_pos + pos) % DEPTH];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // apply one accepted request to the ring and queue the view it leaves
      function void note_request(logic [bdq_pkg::CMD_W-1:0] cmd,
                                 logic [bdq_pkg::DATA_W-1:0] value);
         deque_view_type v;
         int             hit;
         int             j;
         v        = '0;
         v.status = bdq_pkg::STATUS_OK;
         hit      = -1;
         case (cmd) inside
            bdq_pkg::CMD_PUSH_FRONT: begin
               if (fill == DEPTH) v.status = bdq_pkg::STATUS_FULL;
               else begin
                  head_pos        = (head_pos + DEPTH - 1) % DEPTH;
                  slots[head_pos] = value;
                  fill++;
               end
            end
            bdq_pkg::CMD_PUSH_BACK: begin
               if (fill == DEPTH) v.status = bdq_pkg::STATUS_FULL;
               else begin
                  slots[(head_pos + fill) % DEPTH] = value;
                  fill++;
               end
            end
            bdq_pkg::CMD_POP_FRONT: begin
               if (fill == 0) v.status = bdq_pkg::STATUS_EMPTY;
               else begin
                  head_pos = (head_pos + 1) % DEPTH;
                  fill--;
               end
            end
            bdq_pkg::CMD_POP_BACK: begin
               if (fill == 0) v.status = bdq_pkg::STATUS_EMPTY;
               else fill--;
            end
            bdq_pkg::CMD_CONTAINS, bdq_pkg::CMD_REMOVE: begin
               for (int i = 0; i < fill && hit < 0; i++)
                  if (slot_at(i) == value) hit = i;
               v.found = (hit >= 0);
               if (cmd == bdq_pkg::CMD_REMOVE && hit >= 0) begin
                  // close the gap toward the front
                  for (j = hit; j < fill - 1; j++)
                     slots[(head_pos + j) % DEPTH] = slot_at(j + 1);
                  fill--;
               end
            end
            default: ;
         endcase
         v.count     = fill[bdq_pkg::COUNT_W-1:0];
         v.empty_res = (fill == 0);
         if (fill > 0) begin
            v.front_value = slot_at(0);
            v.back_value  = slot_at(fill - 1);
         end
         expected_q.push_back(v);
      endfunction

      function void check_response(deque_view_type got);
         deque_view_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response with no request pending: front=%0d back=%0d count=%0d",
                        got.front_value, got.back_value, got.count);
            return;
         end
         want = expected_q.pop_front();
         if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
             got.count !== want.count || got.empty_res !== want.empty_res ||
             got.found !== want.found || got.status !== want.status) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp front=%0d back=%0d count=%0d empty=%0b found=%0b ",
                         "status=%0d | got front=%0d back=%0d count=%0d empty=%0b found=%0b ",
                         "status=%0d"},
                        want.front_value, want.back_value, want.count, want.empty_res,
                        want.found, want.status, got.front_value, got.back_value,
                        got.count, got.empty_res, got.found, got.status);
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic        [bdq_pkg::CMD_W-1:0]    req_cmd;
   logic signed [bdq_pkg::DATA_W-1:0]   req_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [bdq_pkg::DATA_W-1:0]   rsp_front_value;
   logic signed [bdq_pkg::DATA_W-1:0]   rsp_back_value;
   logic        [bdq_pkg::COUNT_W-1:0]  rsp_count;
   logic                                rsp_empty_res;
   logic                                rsp_found;
   logic        [bdq_pkg::STATUS_W-1:0] rsp_status;

   deque_scoreboard sb;
   int              burst_left;
   bit              hold_wanted;
   int              cycle_count;

   bounded_deque_with_search dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_count       (rsp_count),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_front_value, rsp_back_value, rsp_count,
                            rsp_empty_res, rsp_found, rsp_status});
   end

   // receiver: stall modes that change every so often, plus one long hold
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      int phase;
      bit hold_done;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      hold_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (phase % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // offer one request and hold it until the block takes it
   task automatic offer(input logic [bdq_pkg::CMD_W-1:0] cmd,
                        input logic [bdq_pkg::DATA_W-1:0] value);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, value);
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic drain_responses();
      if (burst_left != 0) begin
         req_valid  <= 1'b0;
         burst_left = 0;
      end
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [bdq_pkg::DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4 && sb.fill > 0) return sb.slot_at($urandom_range(0, sb.fill - 1));
      if (r < 7) begin
         case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VAL_MIN;
            3: return VAL_MAX;
            4: return 32'd1;
            default: return $urandom_range(0, 7);
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [bdq_pkg::CMD_W-1:0] pick_cmd(fill_trend_type trend);
      int r;
      int push_share;
      int pop_share;
      r          = $urandom_range(0, 99);
      push_share = (trend == TREND_GROW) ? 60 : (trend == TREND_SHRINK) ? 15 : 35;
      pop_share  = (trend == TREND_GROW) ? 15 : (trend == TREND_SHRINK) ? 55 : 30;
      if (r < push_share)
         return $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT;
      if (r < push_share + pop_share)
         return $urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT;
      if (r < 96)
         return $urandom_range(0, 1) ? bdq_pkg::CMD_REMOVE : bdq_pkg::CMD_CONTAINS;
      return $urandom_range(0, 1) ? CMD_UNUSED_B : CMD_UNUSED_A;
   endfunction

   initial begin
      fill_trend_type trend;
      int             trend_left;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = bdq_pkg::CMD_PUSH_FRONT;
      req_value   = '0;
      burst_left  = 0;
      hold_wanted = 0;
      cycle_count = 0;
      trend       = TREND_GROW;
      trend_left  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty deque: refused pops, searches that miss, no-ops
      offer(bdq_pkg::CMD_POP_FRONT, '0);
      offer(bdq_pkg::CMD_POP_BACK, '1);
      offer(bdq_pkg::CMD_CONTAINS, '0);
      offer(bdq_pkg::CMD_REMOVE, '0);
      offer(CMD_UNUSED_A, VAL_MAX);
      offer(CMD_UNUSED_B, VAL_MIN);
      // build -1, MIN, MAX, 0 from both ends
      offer(bdq_pkg::CMD_PUSH_BACK, VAL_MAX);
      offer(bdq_pkg::CMD_PUSH_FRONT, VAL_MIN);
      offer(bdq_pkg::CMD_PUSH_BACK, '0);
      offer(bdq_pkg::CMD_PUSH_FRONT, '1);
      offer(bdq_pkg::CMD_CONTAINS, '1);        // match on the front element
      offer(bdq_pkg::CMD_REMOVE, VAL_MIN);     // remove from the middle
      offer(bdq_pkg::CMD_REMOVE, 32'd12345);   // no match
      offer(bdq_pkg::CMD_CONTAINS, 32'd12345);
      // fill to the limit, then push at both ends
      while (sb.fill < DEPTH)
         offer(sb.fill % 2 ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK, $urandom());
      offer(bdq_pkg::CMD_PUSH_FRONT, VAL_MAX);
      offer(bdq_pkg::CMD_PUSH_BACK, VAL_MIN);
      drain_responses();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (trend_left == 0) begin
            trend      = fill_trend_type'($urandom_range(0, 2));
            trend_left = $urandom_range(20, 60);
         end
         trend_left--;
         if (n == 200) hold_wanted = 1;
         if (n == 700 || n == 1200) drain_responses();
         offer(pick_cmd(trend), pick_value());
      end

      drain_responses();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
